[rtl/core/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

    // fixed field widths
    localparam int HUE_W  = 24;
    localparam int IN_W   = 16;
    localparam int CH_W   = 8;

    // hue split widths: quotient by one sector, quotient by six, remainder
    localparam int QUO_W  = 12;
    localparam int QD6_W  = 10;
    localparam int REM_W  = 12;

    // one sector is 60 degrees in 1/64 degree steps
    localparam logic [REM_W-1:0] HUE_SECTOR = 12'd3840;

    // reciprocal of 15 for a 15-bit dividend, exact after the shift
    localparam logic [16:0] RECIP15       = 17'd34953;
    localparam int          RECIP15_SHIFT = 19;

    // reciprocal of 6 for a quotient below 2185, exact after the shift
    localparam logic [12:0] RECIP6        = 13'd5462;
    localparam int          RECIP6_SHIFT  = 15;

    // colour wheel sectors, named by the hues at their ends
    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

    // hue after the division stages
    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic [QD6_W-1:0] quo_div6;
        logic [REM_W-1:0] rem;
    } hue_split_t;

    // the four scaled channel candidates and the sector that picks among them
    typedef struct packed {
        sector_t         sector;
        logic [CH_W-1:0] cv;
        logic [CH_W-1:0] cp;
        logic [CH_W-1:0] cq;
        logic [CH_W-1:0] ct;
    } chan_set_t;

endpackage

[rtl/core/hsv2rgb_front.sv]
module hsv2rgb_front #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [hsv2rgb_pkg::HUE_W-1:0]   hue,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0]    sat,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0]    bri,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output hsv2rgb_pkg::hue_split_t                out_hue,
    output logic [FRAC_BITS:0]                     out_sat,
    output logic [FRAC_BITS:0]                     out_val
);

    localparam int UW = FRAC_BITS + 1;
    localparam logic [16:0] ONE_C = 17'(1) << FRAC_BITS;

    // clamp a signed Q-format input to 0..one
    function automatic logic [UW-1:0] clamp_unit(input logic signed [15:0] raw);
        logic [16:0] mag;
        mag = {2'b00, raw[14:0]};
        if (raw[15]) begin
            return '0;
        end else if (mag > ONE_C) begin
            return ONE_C[UW-1:0];
        end else begin
            return mag[UW-1:0];
        end
    endfunction

    logic        en1, en2;
    logic        vld1_reg, vld2_reg;
    logic [22:0] hue_pos;
    logic [14:0] hue_hi;
    logic [31:0] quo_prod;
    logic [14:0] hue_hi_reg;
    logic [7:0]  hue_lo_reg;
    logic [hsv2rgb_pkg::QUO_W-1:0] quo_reg;
    logic [UW-1:0] sat1_reg, val1_reg, sat2_reg, val2_reg;
    logic [14:0] r15_full;
    logic [24:0] quo6_prod;
    hsv2rgb_pkg::hue_split_t hue_next, hue_reg;

    // stage enables, a bubble is filled even while the output stalls
    assign en2      = !vld2_reg || out_ready;
    assign en1      = !vld1_reg || en2;
    assign in_ready = en1;

    // stage 1: clamp, quotient of the hue by one sector
    assign hue_pos  = hue[23] ? 23'd0 : hue[22:0];
    assign hue_hi   = hue_pos[22:8];
    assign quo_prod = 32'(hue_hi) * 32'(hsv2rgb_pkg::RECIP15);

    // stage 2: remainder within the sector, quotient by six
    assign r15_full  = hue_hi_reg - 15'({quo_reg, 4'b0000}) + 15'(quo_reg);
    assign quo6_prod = 25'(quo_reg) * 25'(hsv2rgb_pkg::RECIP6);

    always_comb begin
        hue_next.quo      = quo_reg;
        hue_next.quo_div6 = quo6_prod[hsv2rgb_pkg::RECIP6_SHIFT +: hsv2rgb_pkg::QD6_W];
        hue_next.rem      = {r15_full[3:0], hue_lo_reg};
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            if (en1) begin
                vld1_reg <= in_valid;
            end
            if (en2) begin
                vld2_reg <= vld1_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            hue_hi_reg <= hue_hi;
            hue_lo_reg <= hue_pos[7:0];
            quo_reg    <= quo_prod[hsv2rgb_pkg::RECIP15_SHIFT +: hsv2rgb_pkg::QUO_W];
            sat1_reg   <= clamp_unit(sat);
            val1_reg   <= clamp_unit(bri);
        end
        if (en2 && vld1_reg) begin
            hue_reg  <= hue_next;
            sat2_reg <= sat1_reg;
            val2_reg <= val1_reg;
        end
    end

    assign out_valid = vld2_reg;
    assign out_hue   = hue_reg;
    assign out_sat   = sat2_reg;
    assign out_val   = val2_reg;

endmodule

[rtl/core/hsv2rgb_chan.sv]
module hsv2rgb_chan #(
    parameter int FRAC_BITS = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  hsv2rgb_pkg::hue_split_t  in_hue,
    input  logic [FRAC_BITS:0]       in_sat,
    input  logic [FRAC_BITS:0]       in_val,
    output logic                     out_valid,
    input  logic                     out_ready,
    output hsv2rgb_pkg::chan_set_t   out_chan
);

    localparam int UW  = FRAC_BITS + 1;
    localparam int NW  = FRAC_BITS + 12;
    localparam int PW  = 2 * FRAC_BITS + 13;
    localparam int YW  = 2 * FRAC_BITS + 18;
    localparam int RSH = 2 * FRAC_BITS + 8;

    localparam logic [UW-1:0] ONE_U    = UW'(1) << FRAC_BITS;
    localparam logic [NW-1:0] FULL_NUM = NW'(hsv2rgb_pkg::HUE_SECTOR) << FRAC_BITS;

    // round(17 * prod / 2^RSH), which equals round(255 * v * num / (one^2 * 3840))
    function automatic logic [7:0] round_chan(input logic [PW-1:0] prod);
        logic [YW-1:0]     y;
        logic [YW-RSH-1:0] r;
        y = YW'(prod) + (YW'(prod) << 4) + (YW'(1) << (RSH - 1));
        r = y[YW-1:RSH];
        if (r > (YW-RSH)'(255)) begin
            return 8'hFF;
        end else begin
            return r[7:0];
        end
    endfunction

    logic en3, en4, en5;
    logic vld3_reg, vld4_reg, vld5_reg;
    logic [hsv2rgb_pkg::QUO_W-1:0] sec_full;
    logic [NW-1:0] num_p, num_q, num_t;
    logic [NW-1:0] num_p3_reg, num_q3_reg, num_t3_reg;
    logic [UW-1:0] val3_reg;
    hsv2rgb_pkg::sector_t sec3_reg, sec4_reg;
    logic [PW-1:0] prod_v4_reg, prod_p4_reg, prod_q4_reg, prod_t4_reg;
    hsv2rgb_pkg::chan_set_t chan_next, chan_reg;

    // stage enables
    assign en5      = !vld5_reg || out_ready;
    assign en4      = !vld4_reg || en5;
    assign en3      = !vld3_reg || en4;
    assign in_ready = en3;

    // stage 3: sector from the quotient, numerators of p, q and t
    assign sec_full = in_hue.quo - hsv2rgb_pkg::QUO_W'({in_hue.quo_div6, 2'b00})
                                 - hsv2rgb_pkg::QUO_W'({in_hue.quo_div6, 1'b0});
    assign num_p = NW'(ONE_U - in_sat) * NW'(hsv2rgb_pkg::HUE_SECTOR);
    assign num_q = FULL_NUM - NW'(in_hue.rem) * NW'(in_sat);
    assign num_t = FULL_NUM - NW'(hsv2rgb_pkg::HUE_SECTOR - in_hue.rem) * NW'(in_sat);

    // stage 5: scale by 255 and round to nearest
    always_comb begin
        chan_next.sector = sec4_reg;
        chan_next.cv     = round_chan(prod_v4_reg);
        chan_next.cp     = round_chan(prod_p4_reg);
        chan_next.cq     = round_chan(prod_q4_reg);
        chan_next.ct     = round_chan(prod_t4_reg);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end else begin
            if (en3) begin
                vld3_reg <= in_valid;
            end
            if (en4) begin
                vld4_reg <= vld3_reg;
            end
            if (en5) begin
                vld5_reg <= vld4_reg;
            end
        end
    end

    // payload, stage 4 forms the value products
    always_ff @(posedge aclk) begin
        if (en3 && in_valid) begin
            sec3_reg   <= hsv2rgb_pkg::sector_t'(sec_full[2:0]);
            val3_reg   <= in_val;
            num_p3_reg <= num_p;
            num_q3_reg <= num_q;
            num_t3_reg <= num_t;
        end
        if (en4 && vld3_reg) begin
            sec4_reg    <= sec3_reg;
            prod_v4_reg <= PW'(val3_reg) * PW'(FULL_NUM);
            prod_p4_reg <= PW'(val3_reg) * PW'(num_p3_reg);
            prod_q4_reg <= PW'(val3_reg) * PW'(num_q3_reg);
            prod_t4_reg <= PW'(val3_reg) * PW'(num_t3_reg);
        end
        if (en5 && vld4_reg) begin
            chan_reg <= chan_next;
        end
    end

    assign out_valid = vld5_reg;
    assign out_chan  = chan_reg;

endmodule

[rtl/core/hsv_to_rgb_converter.sv]
// HSV to RGB colour converter, one pixel per beat.
// Input channel (s_valid/s_ready): s_hue in 1/64 degree, s_saturation and
// s_brightness as signed fixed point with FRAC_BITS fraction bits. Negative
// hue is taken as zero, larger hue wraps modulo 360 degrees, saturation and
// brightness are clamped to 0..1.
// Output channel (m_valid/m_ready): 8-bit m_red, m_green, m_blue, rounded.
// An accepted input beat passes two hue division stages, a numerator stage,
// a multiply stage, a rounding stage and the sector select into the output
// register before m_valid rises.
// Throughput is one beat per cycle while s_ready is high; every stage carries
// its own valid bit. When m_ready is low the output register holds its beat,
// and the stages behind it keep filling bubbles; s_ready falls only once all
// six are full. Nothing is lost or repeated across a stall.
// Reset (aresetn low, synchronous) clears all valid bits, so the block starts
// empty; no other state is reset.
module hsv_to_rgb_converter #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [hsv2rgb_pkg::HUE_W-1:0] s_hue,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0]  s_saturation,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0]  s_brightness,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [hsv2rgb_pkg::CH_W-1:0]         m_red,
    output logic [hsv2rgb_pkg::CH_W-1:0]         m_green,
    output logic [hsv2rgb_pkg::CH_W-1:0]         m_blue
);

    logic                    front_valid, front_ready;
    hsv2rgb_pkg::hue_split_t front_hue;
    logic [FRAC_BITS:0]      front_sat, front_val;
    logic                    chan_valid, chan_ready;
    hsv2rgb_pkg::chan_set_t  chan;
    logic                    en6;
    logic                    m_valid_reg;
    logic [hsv2rgb_pkg::CH_W-1:0] red_reg, green_reg, blue_reg;
    logic [hsv2rgb_pkg::CH_W-1:0] red_next, green_next, blue_next;

    // clamp and hue split
    hsv2rgb_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .hue       (s_hue),
        .sat       (s_saturation),
        .bri       (s_brightness),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_hue   (front_hue),
        .out_sat   (front_sat),
        .out_val   (front_val)
    );

    // channel candidates v, p, q, t
    hsv2rgb_chan #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_hue    (front_hue),
        .in_sat    (front_sat),
        .in_val    (front_val),
        .out_valid (chan_valid),
        .out_ready (chan_ready),
        .out_chan  (chan)
    );

    // sector select
    always_comb begin
        case (chan.sector)
            hsv2rgb_pkg::SEC_R_Y: begin
                red_next = chan.cv; green_next = chan.ct; blue_next = chan.cp;
            end
            hsv2rgb_pkg::SEC_Y_G: begin
                red_next = chan.cq; green_next = chan.cv; blue_next = chan.cp;
            end
            hsv2rgb_pkg::SEC_G_C: begin
                red_next = chan.cp; green_next = chan.cv; blue_next = chan.ct;
            end
            hsv2rgb_pkg::SEC_C_B: begin
                red_next = chan.cp; green_next = chan.cq; blue_next = chan.cv;
            end
            hsv2rgb_pkg::SEC_B_M: begin
                red_next = chan.ct; green_next = chan.cp; blue_next = chan.cv;
            end
            default: begin
                red_next = chan.cv; green_next = chan.cp; blue_next = chan.cq;
            end
        endcase
    end

    // output register
    assign en6        = !m_valid_reg || m_ready;
    assign chan_ready = en6;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en6) begin
            m_valid_reg <= chan_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en6 && chan_valid) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

endmodule

[rtl/core/hsv2rgb_checker.sv]
module hsv2rgb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_red,
    input logic [7:0]  m_green,
    input logic [7:0]  m_blue
);

    // the pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // a stalled output beat holds its colour
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
                                && $stable(m_blue))
        else $error("stalled output beat changed");

    // input back-pressure only when the output is full and stalled
    a_ready_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while the output could move");

    // with the receiver ready throughout, an accepted beat moves through every stage without a hold
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
            ##1 m_ready |=> m_valid)
        else $error("beat did not reach the output in six cycles");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);
